// ===== rtl/grex_pkg.sv =====
// ----------------------------------------------------------------------------
// grex_pkg
// Shared types, constants and the row expansion function of the glyph row
// expander.
// ----------------------------------------------------------------------------
`default_nettype none

package grex_pkg;

  localparam int FIRST_CODE = 32;
  localparam int LAST_CODE  = 126;
  localparam int MAX_GRAY   = 15;
  localparam int DIM_MAX    = 16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  localparam logic [1:0] REG_FONT_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FONT_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_COLUMN_OFFSET = 2'd2;
  localparam logic [1:0] REG_ROW_OFFSET    = 2'd3;

  localparam logic [4:0] RST_FONT_WIDTH    = 5'd8;
  localparam logic [4:0] RST_FONT_HEIGHT   = 5'd16;
  localparam logic [7:0] RST_COLUMN_OFFSET = 8'd28;
  localparam logic [7:0] RST_ROW_OFFSET    = 8'd0;

  typedef struct packed {
    logic [4:0] font_width;
    logic [4:0] font_height;
    logic [7:0] column_offset;
    logic [7:0] row_offset;
  } cfg_t;

  typedef struct packed {
    logic [4:0] width;
    logic [3:0] level;
    logic [7:0] cstart;
    logic [3:0] bytes;
    logic [7:0] row_address;
    logic       last;
    logic       blank;
  } row_ctx_t;

  function automatic logic [63:0] expand_row(input logic [15:0] mask,
                                             input logic [4:0]  width,
                                             input logic [3:0]  level);
    logic [63:0] packed_row;
    packed_row = '0;
    for (int c = 0; c < 16; c++) begin
      if ((5'(c) < width) && mask[15 - c]) begin
        packed_row[63 - 4*c -: 4] = level;
      end
    end
    return packed_row;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/grex_if.sv =====
// ----------------------------------------------------------------------------
// grex_if
// Valid/ready channels for draw and load items and for row results.
// ----------------------------------------------------------------------------
`default_nettype none

interface grex_in_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic [10:0]       glyph_address;
  logic [15:0]       glyph_word;
  logic [7:0]        char_code;
  logic signed [9:0] x_pos;
  logic signed [7:0] y_pos;
  logic [7:0]        gray;

  modport source (output valid, command, glyph_address, glyph_word, char_code,
                  x_pos, y_pos, gray, input ready);
  modport sink   (input valid, command, glyph_address, glyph_word, char_code,
                  x_pos, y_pos, gray, output ready);
endinterface

interface grex_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  column_start;
  logic [7:0]  column_end;
  logic [7:0]  row_address;
  logic [63:0] pixel_bytes;
  logic [3:0]  byte_count;
  logic        last_row;

  modport source (output valid, column_start, column_end, row_address, pixel_bytes,
                  byte_count, last_row, input ready);
  modport sink   (input valid, column_start, column_end, row_address, pixel_bytes,
                  byte_count, last_row, output ready);
endinterface

`default_nettype wire

// ===== rtl/glyph_row_expander_4bpp_core.sv =====
// ----------------------------------------------------------------------------
// glyph_row_expander_4bpp_core
// Glyph store and row sequencer of a 4 bpp bitmap font character generator.
// ----------------------------------------------------------------------------
// A load item writes one 16-bit row mask into the glyph store. A draw item of a
// printable character that fits on the screen reads the store once per font
// row, the font height saturated at sixteen, one row per cycle through the
// single read port while the result side takes rows, and gives one result per
// row; the input accepts again once the last row has moved on to the result
// register, later while the result side stalls. Store entries hold no value
// until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_row_expander_4bpp_core
  import grex_pkg::*;
#(
  parameter int GLYPH_WORDS   = 2048,
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  grex_in_if.sink          in_chan,
  grex_out_if.source       out_chan,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int AW = $clog2(GLYPH_WORDS);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_ISSUE = 2'b10
  } state_t;

  cfg_t     cfg;
  row_ctx_t ctx;

  state_t      state_r, state_nxt;
  logic [10:0] base_r;
  logic [4:0]  w_r;
  logic [4:0]  h_r;
  logic [3:0]  level_r;
  logic [7:0]  cstart_r;
  logic [3:0]  bytes_r;
  logic [7:0]  rowbase_r;
  logic [3:0]  row_r;
  logic        pend_r, pend_nxt;
  logic [3:0]  pend_row_r;
  logic        pend_last_r;
  logic        pend_blank_r;

  logic        in_xfer;
  logic [4:0]  w_sat;
  logic [4:0]  h_sat;
  logic        code_ok;
  logic [10:0] x_end;
  logic [7:0]  y_end;
  logic        x_ok;
  logic        y_ok;
  logic        draw_ok;
  logic [6:0]  code_idx;
  logic [10:0] base;
  logic        ram_we;
  logic        issue;
  logic [10:0] idx;
  logic        row_last;
  logic        out_load;
  logic        load_ok;
  logic [15:0] mask;

  grex_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign in_chan.ready = (state_r == ST_IDLE) & ~pend_r;
  assign in_xfer       = in_chan.valid & in_chan.ready;

  always_comb begin
    w_sat    = (cfg.font_width  > 5'(DIM_MAX)) ? 5'(DIM_MAX) : cfg.font_width;
    h_sat    = (cfg.font_height > 5'(DIM_MAX)) ? 5'(DIM_MAX) : cfg.font_height;
    code_ok  = (in_chan.char_code >= 8'(FIRST_CODE)) && (in_chan.char_code <= 8'(LAST_CODE));
    x_end    = {2'b00, in_chan.x_pos[8:0]} + {6'd0, w_sat};
    y_end    = {1'b0, in_chan.y_pos[6:0]} + {3'd0, h_sat};
    x_ok     = ~in_chan.x_pos[9] && (x_end <= 11'(SCREEN_WIDTH));
    y_ok     = ~in_chan.y_pos[7] && (y_end <= 8'(SCREEN_HEIGHT));
    draw_ok  = (in_chan.command == CMD_DRAW) && code_ok && (w_sat != 5'd0) &&
               (h_sat != 5'd0) && x_ok && y_ok;
    code_idx = 7'(in_chan.char_code - 8'(FIRST_CODE));
    base     = 11'({4'd0, code_idx} * {6'd0, h_sat});
  end

  assign ram_we = in_xfer && (in_chan.command == CMD_LOAD) &&
                  (32'(in_chan.glyph_address) < GLYPH_WORDS);

  assign out_load = pend_r & load_ok;
  assign issue    = (state_r == ST_ISSUE) & (~pend_r | out_load);
  assign idx      = base_r + {7'd0, row_r};
  assign row_last = ({1'b0, row_r} == (h_r - 5'd1));

  grex_ram #(
    .WIDTH (16),
    .DEPTH (GLYPH_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_chan.glyph_address)),
    .wdata (in_chan.glyph_word),
    .re    (issue),
    .raddr (AW'(idx)),
    .rdata (mask)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_xfer && draw_ok) state_nxt = ST_ISSUE;
      ST_ISSUE: if (issue && row_last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    if (issue) begin
      pend_nxt = 1'b1;
    end else if (out_load) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      if (in_xfer) begin
        row_r <= '0;
      end else if (issue) begin
        row_r <= row_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      base_r    <= base;
      w_r       <= w_sat;
      h_r       <= h_sat;
      level_r   <= (|in_chan.gray[7:4]) ? 4'(MAX_GRAY) : in_chan.gray[3:0];
      cstart_r  <= cfg.column_offset + in_chan.x_pos[8:1];
      bytes_r   <= 4'(({1'b0, w_sat} + 6'd1) >> 1);
      rowbase_r <= cfg.row_offset + in_chan.y_pos;
    end
    if (issue) begin
      pend_row_r   <= row_r;
      pend_last_r  <= row_last;
      pend_blank_r <= (32'(idx) >= GLYPH_WORDS);
    end
  end

  always_comb begin
    ctx.width       = w_r;
    ctx.level       = level_r;
    ctx.cstart      = cstart_r;
    ctx.bytes       = bytes_r;
    ctx.row_address = rowbase_r + {4'd0, pend_row_r};
    ctx.last        = pend_last_r;
    ctx.blank       = pend_blank_r;
  end

  grex_rowout u_rowout (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (out_load),
    .ctx      (ctx),
    .mask     (mask),
    .load_ok  (load_ok),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

// ===== rtl/grex_ram.sv =====
// ----------------------------------------------------------------------------
// grex_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module grex_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/grex_cfg.sv =====
// ----------------------------------------------------------------------------
// grex_cfg
// APB register bank: font size and controller address offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module grex_cfg
  import grex_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.font_width    <= RST_FONT_WIDTH;
      cfg_r.font_height   <= RST_FONT_HEIGHT;
      cfg_r.column_offset <= RST_COLUMN_OFFSET;
      cfg_r.row_offset    <= RST_ROW_OFFSET;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_FONT_WIDTH:    cfg_r.font_width    <= pwdata[4:0];
        REG_FONT_HEIGHT:   cfg_r.font_height   <= pwdata[4:0];
        REG_COLUMN_OFFSET: cfg_r.column_offset <= pwdata[7:0];
        REG_ROW_OFFSET:    cfg_r.row_offset    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FONT_WIDTH:    prdata = {27'd0, cfg_r.font_width};
      REG_FONT_HEIGHT:   prdata = {27'd0, cfg_r.font_height};
      REG_COLUMN_OFFSET: prdata = {24'd0, cfg_r.column_offset};
      REG_ROW_OFFSET:    prdata = {24'd0, cfg_r.row_offset};
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/grex_rowout.sv =====
// ----------------------------------------------------------------------------
// grex_rowout
// Expand one glyph row to packed 4-bit pixels and hold it in the result
// register until transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module grex_rowout
  import grex_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,
  input  row_ctx_t          ctx,
  input  wire logic [15:0]  mask,
  output logic              load_ok,
  grex_out_if.source        out_chan
);

  logic        valid_r, valid_nxt;
  logic [7:0]  cstart_r;
  logic [7:0]  cend_r;
  logic [7:0]  row_addr_r;
  logic [63:0] pixels_r;
  logic [3:0]  bytes_r;
  logic        last_r;

  assign load_ok = ~valid_r | out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cstart_r   <= ctx.cstart;
      cend_r     <= ctx.cstart + {4'd0, ctx.bytes} - 8'd1;
      row_addr_r <= ctx.row_address;
      pixels_r   <= expand_row(ctx.blank ? 16'd0 : mask, ctx.width, ctx.level);
      bytes_r    <= ctx.bytes;
      last_r     <= ctx.last;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.column_start = cstart_r;
  assign out_chan.column_end   = cend_r;
  assign out_chan.row_address  = row_addr_r;
  assign out_chan.pixel_bytes  = pixels_r;
  assign out_chan.byte_count   = bytes_r;
  assign out_chan.last_row     = last_r;

endmodule

`default_nettype wire

// ===== bench/glyph_row_expander_4bpp_core_test.sv =====
// ----------------------------------------------------------------------------
// glyph_row_expander_4bpp_core_test
// Self-checking bench for the 4 bpp glyph row expander. Glyph rows are loaded
// over the input channel, characters are drawn under several font settings
// written over the APB port, and every row transfer is checked field by field
// against an in-bench predictor that keeps its own copy of the glyph store.
// Both channels idle and stall in random bursts until the final stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_row_expander_4bpp_core_test;
  import grex_pkg::*;

  localparam int STORE_WORDS   = 2048;
  localparam int SCREEN_W      = 256;
  localparam int SCREEN_H      = 64;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEM_TARGET   = 320;

  typedef struct {
    logic              command;
    logic [10:0]       glyph_address;
    logic [15:0]       glyph_word;
    logic [7:0]        char_code;
    logic signed [9:0] x_pos;
    logic signed [7:0] y_pos;
    logic [7:0]        gray;
  } glyph_cmd_t;

  typedef struct {
    logic [7:0]  column_start;
    logic [7:0]  column_end;
    logic [7:0]  row_address;
    logic [63:0] pixel_bytes;
    logic [3:0]  byte_count;
    logic        last_row;
  } row_image_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  grex_in_if  in_chan();
  grex_out_if out_chan();

  glyph_row_expander_4bpp_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  logic [15:0] glyph_mem [STORE_WORDS];
  bit          loaded    [STORE_WORDS];
  logic [4:0]  font_w;
  logic [4:0]  font_h;
  logic [7:0]  col_off;
  logic [7:0]  row_off;

  row_image_t  pending_rows[$];
  bit          quiet;
  int          mismatches;
  int          rows_checked;
  int          items_sent;
  int          loads_sent;
  int          draws_sent;
  int          settings_used;
  int          cycle_count;
  int          stall_left;

  logic [7:0]  code_pool [6] = '{8'd32, 8'd126, 8'd65, 8'd77, 8'd103, 8'd90};

  always #1 clk = ~clk;

  function automatic int clamp_dim(input logic [4:0] v);
    return (v > DIM_MAX) ? DIM_MAX : int'(v);
  endfunction

  // Update the glyph store or queue the rows that a draw produces.
  function automatic void expand_glyph_rows(input glyph_cmd_t it);
    int          w;
    int          h;
    int          x;
    int          y;
    int          nbytes;
    int          base;
    logic [3:0]  lvl;
    logic [15:0] mask;
    row_image_t  r;
    if (it.command == CMD_LOAD) begin
      glyph_mem[it.glyph_address] = it.glyph_word;
      return;
    end
    if (it.char_code < FIRST_CODE || it.char_code > LAST_CODE) return;
    lvl = (it.gray > MAX_GRAY) ? 4'(MAX_GRAY) : it.gray[3:0];
    w = clamp_dim(font_w);
    h = clamp_dim(font_h);
    if (w == 0 || h == 0) return;
    x = int'(it.x_pos);
    y = int'(it.y_pos);
    if (x < 0 || x + w > SCREEN_W || y < 0 || y + h > SCREEN_H) return;
    nbytes = (w + 1) / 2;
    base = (int'(it.char_code) - FIRST_CODE) * h;
    for (int row = 0; row < h; row++) begin
      mask = (base + row < STORE_WORDS) ? glyph_mem[base + row] : 16'h0000;
      r.column_start = col_off + 8'(x >> 1);
      r.column_end   = r.column_start + 8'(nbytes - 1);
      r.row_address  = row_off + 8'(y + row);
      r.byte_count   = 4'(nbytes);
      r.last_row     = (row == h - 1);
      r.pixel_bytes  = '0;
      for (int c = 0; c < w; c++) begin
        if (mask[15 - c]) r.pixel_bytes[63 - 4*c -: 4] = lvl;
      end
      pending_rows.push_back(r);
    end
  endfunction

  task automatic send_item(input glyph_cmd_t it);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.command       <= it.command;
    in_chan.glyph_address <= it.glyph_address;
    in_chan.glyph_word    <= it.glyph_word;
    in_chan.char_code     <= it.char_code;
    in_chan.x_pos         <= it.x_pos;
    in_chan.y_pos         <= it.y_pos;
    in_chan.gray          <= it.gray;
    do @(posedge clk); while (!in_chan.ready);
    expand_glyph_rows(it);
    items_sent++;
    if (it.command == CMD_LOAD) loads_sent++;
    else draws_sent++;
  endtask

  task automatic send_load(input int addr, input logic [15:0] word);
    glyph_cmd_t it;
    it.command       = CMD_LOAD;
    it.glyph_address = addr[10:0];
    it.glyph_word    = word;
    it.char_code     = 8'($urandom);
    it.x_pos         = 10'($urandom);
    it.y_pos         = 8'($urandom);
    it.gray          = 8'($urandom);
    loaded[addr[10:0]] = 1'b1;
    send_item(it);
  endtask

  task automatic send_draw(input logic [7:0] code, input int x, input int y,
                           input logic [7:0] gray);
    glyph_cmd_t it;
    it.command       = CMD_DRAW;
    it.glyph_address = 11'($urandom);
    it.glyph_word    = 16'($urandom);
    it.char_code     = code;
    it.x_pos         = x[9:0];
    it.y_pos         = y[7:0];
    it.gray          = gray;
    send_item(it);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 16'hFFFF;
      1:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Load every missing row of a glyph, and reload some rows at random.
  task automatic prepare_glyph(input logic [7:0] code);
    int h;
    int idx;
    h = clamp_dim(font_h);
    for (int row = 0; row < h; row++) begin
      idx = (int'(code) - FIRST_CODE) * h + row;
      if (!loaded[idx] || $urandom_range(0, 7) == 0) send_load(idx, pick_word());
    end
  endtask

  // Stop sending and hold until every row is back and the block settles.
  task automatic drain_rows();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_FONT_WIDTH:    font_w  = value[4:0];
      REG_FONT_HEIGHT:   font_h  = value[4:0];
      REG_COLUMN_OFFSET: col_off = value[7:0];
      REG_ROW_OFFSET:    row_off = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_font(input logic [4:0] w, input logic [4:0] h,
                          input logic [7:0] co, input logic [7:0] ro);
    drain_rows();
    write_reg(REG_FONT_WIDTH, 32'(w));
    write_reg(REG_FONT_HEIGHT, 32'(h));
    write_reg(REG_COLUMN_OFFSET, 32'(co));
    write_reg(REG_ROW_OFFSET, 32'(ro));
    settings_used++;
  endtask

  function automatic logic [7:0] pick_printable();
    if ($urandom_range(0, 3) != 0) return code_pool[$urandom_range(0, 5)];
    return 8'($urandom_range(FIRST_CODE, LAST_CODE));
  endfunction

  task automatic random_items(input int count);
    int         kind;
    int         w;
    int         h;
    int         x;
    int         y;
    logic [7:0] code;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      w = clamp_dim(font_w);
      h = clamp_dim(font_h);
      if (kind < 60) begin
        code = pick_printable();
        prepare_glyph(code);
        case ($urandom_range(0, 5))
          0:       begin x = 0;            y = 0;            end
          1:       begin x = SCREEN_W - w; y = SCREEN_H - h; end
          default: begin
            x = $urandom_range(0, SCREEN_W - w);
            y = $urandom_range(0, SCREEN_H - h);
          end
        endcase
        send_draw(code, x, y, 8'($urandom));
      end else if (kind < 70) begin
        send_load($urandom_range(0, STORE_WORDS - 1), pick_word());
      end else if (kind < 80) begin
        code = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, FIRST_CODE - 1))
                                           : 8'($urandom_range(LAST_CODE + 1, 255));
        send_draw(code, $urandom_range(0, 1023), $urandom_range(0, 255), 8'($urandom));
      end else begin
        code = pick_printable();
        prepare_glyph(code);
        x = $urandom_range(0, SCREEN_W - w);
        y = $urandom_range(0, SCREEN_H - h);
        case ($urandom_range(0, 4))
          0: x = -$urandom_range(1, 512);
          1: x = $urandom_range(SCREEN_W - w + 1, 511);
          2: y = -$urandom_range(1, 128);
          3: y = $urandom_range(SCREEN_H - h + 1, 127);
          default: begin
            x = $urandom_range(0, 1023);
            y = $urandom_range(0, 255);
          end
        endcase
        send_draw(code, x, y, 8'($urandom));
      end
    end
  endtask

  task automatic test_reset_font();
    logic [15:0] words [6] = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'hAAAA, 16'h5555};
    for (int row = 0; row < 16; row++) begin
      send_load(row, (row < 6) ? words[row] : 16'($urandom));
    end
    send_draw(8'd32, 0, 0, 8'd0);
    send_draw(8'd32, SCREEN_W - 8, SCREEN_H - 16, 8'd255);
    send_draw(8'd32, 3, 7, 8'd15);
    send_draw(8'd32, 100, 20, 8'd16);
    send_draw(8'd31, 10, 10, 8'd9);
    send_draw(8'd127, 10, 10, 8'd9);
    send_draw(8'd255, 10, 10, 8'd9);
    send_draw(8'd32, -1, 0, 8'd5);
    send_draw(8'd32, SCREEN_W - 7, 0, 8'd5);
    send_draw(8'd32, 0, -1, 8'd5);
    send_draw(8'd32, 0, SCREEN_H - 15, 8'd5);
  endtask

  task automatic test_font_extremes();
    set_font(5'd16, 5'd16, 8'd0, 8'd255);
    random_items(14);
    set_font(5'd1, 5'd1, 8'd255, 8'd0);
    random_items(14);
    set_font(5'd31, 5'd31, 8'd200, 8'd250);
    random_items(14);
    set_font(5'd0, 5'd8, 8'd28, 8'd0);
    random_items(8);
    set_font(5'd8, 5'd0, 8'd28, 8'd0);
    random_items(8);
    set_font(5'd15, 5'd4, 8'd255, 8'd255);
    random_items(14);
  endtask

  task automatic test_random_traffic();
    while (items_sent < ITEM_TARGET - 20) begin
      if ($urandom_range(0, 4) != 0) begin
        set_font(5'($urandom_range(1, 16)), 5'($urandom_range(1, 8)), 8'($urandom),
                 8'($urandom));
      end else begin
        set_font(5'($urandom), 5'($urandom), 8'($urandom), 8'($urandom));
      end
      random_items($urandom_range(10, 30));
    end
  endtask

  task automatic test_back_to_back();
    set_font(5'd8, 5'd8, 8'd28, 8'd0);
    quiet = 1'b1;
    random_items(20);
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  always @(posedge clk) begin
    row_image_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_rows.size() == 0) begin
        note_mismatch("unexpected row", '0, out_chan.pixel_bytes);
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (out_chan.column_start !== want.column_start)
          note_mismatch("column_start", 64'(want.column_start), 64'(out_chan.column_start));
        if (out_chan.column_end !== want.column_end)
          note_mismatch("column_end", 64'(want.column_end), 64'(out_chan.column_end));
        if (out_chan.row_address !== want.row_address)
          note_mismatch("row_address", 64'(want.row_address), 64'(out_chan.row_address));
        if (out_chan.pixel_bytes !== want.pixel_bytes)
          note_mismatch("pixel_bytes", want.pixel_bytes, out_chan.pixel_bytes);
        if (out_chan.byte_count !== want.byte_count)
          note_mismatch("byte_count", 64'(want.byte_count), 64'(out_chan.byte_count));
        if (out_chan.last_row !== want.last_row)
          note_mismatch("last_row", 64'(want.last_row), 64'(out_chan.last_row));
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d rows outstanding", pending_rows.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    cfg_psel              = 1'b0;
    cfg_penable           = 1'b0;
    cfg_pwrite            = 1'b0;
    cfg_paddr             = '0;
    cfg_pwdata            = '0;
    in_chan.valid         = 1'b0;
    in_chan.command       = CMD_LOAD;
    in_chan.glyph_address = '0;
    in_chan.glyph_word    = '0;
    in_chan.char_code     = '0;
    in_chan.x_pos         = '0;
    in_chan.y_pos         = '0;
    in_chan.gray          = '0;
    out_chan.ready        = 1'b0;
    font_w                = RST_FONT_WIDTH;
    font_h                = RST_FONT_HEIGHT;
    col_off               = RST_COLUMN_OFFSET;
    row_off               = RST_ROW_OFFSET;
    quiet                 = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_font();
    test_font_extremes();
    test_random_traffic();
    test_back_to_back();
    drain_rows();

    $display("covered %0d loads and %0d draws under %0d font settings plus reset defaults",
             loads_sent, draws_sent, settings_used);
    $display("checked %0d row transfers, %0d mismatches", rows_checked, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/grex_pkg.sv
rtl/grex_if.sv
rtl/grex_ram.sv
rtl/grex_cfg.sv
rtl/grex_rowout.sv
rtl/glyph_row_expander_4bpp_core.sv
bench/glyph_row_expander_4bpp_core_test.sv
